// ===== rtl/lzsd_pkg.sv =====
// Shared types and constants for the LZ stream decompressor.
// No dependencies; compiled before every other file of the block.
package lzsd_pkg;

   localparam int HISTORY_DEPTH_DEFAULT = 65536;
   localparam int QUEUE_DEPTH           = 2;

   localparam int SIZE_W   = 17;
   localparam int COUNT_W  = 17;
   localparam int OFFSET_W = 16;
   localparam int RUN_W    = 15;

   localparam logic [SIZE_W-1:0]  OUTPUT_SIZE_RESET = 17'h10000;
   localparam logic [COUNT_W-1:0] COUNT_MAX         = 17'h1FFFF;

   // request kinds on the input channel
   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_BUSY   = 2'd1,
      ST_BADREF = 2'd2,
      ST_DONE   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_LIT  = 2'd1,
      OP_COPY = 2'd2
   } op_type;

   // One classified operation. Addresses are already reduced modulo the history depth.
   typedef struct packed {
      op_type            op;
      logic [7:0]        data;
      logic [OFFSET_W-1:0] src;
      logic [OFFSET_W-1:0] dst;
      logic              copy_pending;
      logic              done_res;
      status_type        status;
   } entry_type;

   typedef struct packed {
      logic      push;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic      not_empty;
      entry_type entry;
   } head_type;

endpackage

// ===== rtl/lzsd_if.sv =====
// Channel interfaces of the LZ stream decompressor: compressed requests in,
// decompressed results out. No dependencies.
interface lzsd_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] in_byte;

   modport source (output valid, output req_type, output in_byte, input ready);
   modport sink   (input valid, input req_type, input in_byte, output ready);
endinterface

interface lzsd_rsp_if;
   logic       valid;
   logic       ready;
   logic       out_valid;
   logic [7:0] out_byte;
   logic       copy_pending;
   logic       done_res;
   logic [1:0] status;

   modport source (output valid, output out_valid, output out_byte, output copy_pending,
                   output done_res, output status, input ready);
   modport sink   (input valid, input out_valid, input out_byte, input copy_pending,
                   input done_res, input status, output ready);
endinterface

// ===== rtl/lzsd_front.sv =====
// Token parser: accepts requests, tracks header/offset/run state and output count,
// and pushes one classified operation per request. Depends on lzsd_pkg, lzsd_if.
module lzsd_front #(
   parameter int HISTORY_DEPTH = lzsd_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   lzsd_req_if.sink                       req_if,
   input  logic                           csr_we,
   input  logic [lzsd_pkg::SIZE_W-1:0]    csr_wdata,
   input  logic                           q_full,
   output lzsd_pkg::push_type             q_push
);
   import lzsd_pkg::*;

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int HW = AW + 1;
   localparam logic [AW-1:0] LAST_IDX = AW'(HISTORY_DEPTH - 1);
   localparam logic [HW-1:0] DEPTH_H  = HW'(HISTORY_DEPTH);

   // (hi * 256) mod depth for every high offset byte
   function automatic logic [256*AW-1:0] build_hi_mod();
      logic [256*AW-1:0] t;
      for (int i = 0; i < 256; i++) begin
         t[i*AW +: AW] = AW'((i * 256) % HISTORY_DEPTH);
      end
      return t;
   endfunction

   localparam logic [256*AW-1:0] HI_MOD = build_hi_mod();

   typedef enum logic [5:0] {
      PH_HDR_LO = 6'b000001,
      PH_HDR_HI = 6'b000010,
      PH_OFS_LO = 6'b000100,
      PH_OFS_HI = 6'b001000,
      PH_LIT    = 6'b010000,
      PH_COPY   = 6'b100000
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [7:0]            header_low_ff, header_low_in;
   logic [RUN_W-1:0]      run_ff, run_in;
   logic [OFFSET_W-1:0]   copy_source_ff, copy_source_in;
   logic [AW-1:0]         src_idx_ff, src_idx_in;
   logic [AW-1:0]         wr_idx_ff, wr_idx_in;
   logic [COUNT_W-1:0]    out_count_ff, out_count_in;
   logic [SIZE_W-1:0]     output_size_ff, output_size_in;

   logic                  accept;
   logic                  at_done;
   logic                  emit;
   logic [OFFSET_W-1:0]   offset_full;
   entry_type             entry;

   // offset modulo history depth: high byte through the table, low byte added,
   // one correcting subtract since both parts are below the depth
   function automatic logic [AW-1:0] depth_mod(input logic [OFFSET_W-1:0] x);
      logic [HW-1:0] s;
      s = HW'(HI_MOD[x[15:8]*AW +: AW]) + HW'(x[7:0]);
      if (s >= DEPTH_H) begin
         s = s - DEPTH_H;
      end
      return s[AW-1:0];
   endfunction

   assign accept       = req_if.valid && req_if.ready;
   assign req_if.ready = !q_full;
   assign at_done      = (phase_ff == PH_HDR_LO) && (out_count_ff >= output_size_ff);
   assign offset_full  = {req_if.in_byte, copy_source_ff[7:0]};

   always_comb begin
      phase_in       = phase_ff;
      header_low_in  = header_low_ff;
      run_in         = run_ff;
      copy_source_in = copy_source_ff;
      src_idx_in     = src_idx_ff;
      emit           = 1'b0;
      entry.op       = OP_NONE;
      entry.data     = req_if.in_byte;
      entry.src      = OFFSET_W'(src_idx_ff);
      entry.dst      = OFFSET_W'(wr_idx_ff);
      entry.status   = ST_OK;

      if (at_done) begin
         entry.status = ST_DONE;
      end else if (phase_ff == PH_COPY) begin
         if (req_if.req_type == REQ_TICK) begin
            entry.op       = OP_COPY;
            emit           = 1'b1;
            copy_source_in = copy_source_ff + 1'b1;
            // source index follows the 16-bit offset wrap as well as the depth wrap
            if (copy_source_ff == '1 || src_idx_ff == LAST_IDX) begin
               src_idx_in = '0;
            end else begin
               src_idx_in = src_idx_ff + 1'b1;
            end
            run_in = run_ff - 1'b1;
            if (run_ff == RUN_W'(1)) begin
               phase_in = PH_HDR_LO;
            end
         end else begin
            entry.status = ST_BUSY;
         end
      end else if (req_if.req_type == REQ_BYTE) begin
         unique case (phase_ff)
            PH_HDR_LO: begin
               header_low_in = req_if.in_byte;
               phase_in      = PH_HDR_HI;
            end
            PH_HDR_HI: begin
               run_in = {req_if.in_byte[6:0], header_low_ff};
               if (req_if.in_byte[7]) begin
                  phase_in = PH_OFS_LO;
               end else if ({req_if.in_byte[6:0], header_low_ff} != '0) begin
                  phase_in = PH_LIT;
               end else begin
                  phase_in = PH_HDR_LO;
               end
            end
            PH_OFS_LO: begin
               copy_source_in = {8'h00, req_if.in_byte};
               phase_in       = PH_OFS_HI;
            end
            PH_OFS_HI: begin
               copy_source_in = offset_full;
               src_idx_in     = depth_mod(offset_full);
               if (run_ff == '0) begin
                  phase_in = PH_HDR_LO;
               end else if ({1'b0, offset_full} >= out_count_ff) begin
                  entry.status = ST_BADREF;
                  run_in       = '0;
                  phase_in     = PH_HDR_LO;
               end else begin
                  phase_in = PH_COPY;
               end
            end
            PH_LIT: begin
               entry.op = OP_LIT;
               emit     = 1'b1;
               run_in   = run_ff - 1'b1;
               if (run_ff == RUN_W'(1)) begin
                  phase_in = PH_HDR_LO;
               end
            end
            default: begin
               phase_in = PH_HDR_LO;
            end
         endcase
      end

      out_count_in = out_count_ff;
      wr_idx_in    = wr_idx_ff;
      if (emit && out_count_ff != COUNT_MAX) begin
         out_count_in = out_count_ff + 1'b1;
         wr_idx_in    = (wr_idx_ff == LAST_IDX) ? '0 : wr_idx_ff + 1'b1;
      end

      entry.copy_pending = (phase_in == PH_COPY);
      entry.done_res     = (phase_in == PH_HDR_LO) && (out_count_in >= output_size_ff);
   end

   assign output_size_in = csr_we ? csr_wdata : output_size_ff;
   assign q_push.push    = accept;
   assign q_push.entry   = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HDR_LO;
         header_low_ff  <= '0;
         run_ff         <= '0;
         copy_source_ff <= '0;
         src_idx_ff     <= '0;
         wr_idx_ff      <= '0;
         out_count_ff   <= '0;
         output_size_ff <= OUTPUT_SIZE_RESET;
      end else begin
         output_size_ff <= output_size_in;
         if (accept) begin
            phase_ff       <= phase_in;
            header_low_ff  <= header_low_in;
            run_ff         <= run_in;
            copy_source_ff <= copy_source_in;
            src_idx_ff     <= src_idx_in;
            wr_idx_ff      <= wr_idx_in;
            out_count_ff   <= out_count_in;
         end
      end
   end

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> out_count_ff >= $past(out_count_ff))
      else $error("output count went backwards");

   a_copy_has_run: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_COPY |-> run_ff != '0)
      else $error("copy phase with zero remaining length");

endmodule

// ===== rtl/lzsd_queue.sv =====
// Short FIFO between the token parser and the history engine.
// Depends on lzsd_pkg.
module lzsd_queue (
   input  logic                clock,
   input  logic                reset,
   input  lzsd_pkg::push_type  q_push,
   output logic                q_full,
   input  logic                q_pop,
   output lzsd_pkg::head_type  q_head
);
   import lzsd_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_pop;

   assign q_full           = (count_ff == FULL_CNT);
   assign q_head.not_empty = (count_ff != '0);
   assign q_head.entry     = slot_ff[rd_ptr_ff];
   assign do_pop           = q_pop && q_head.not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (q_push.push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (q_push.push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!q_push.push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push.push) begin
         slot_ff[wr_ptr_ff] <= q_push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push.push)
      else $error("push into a full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count out of range");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_head.not_empty)
      else $error("pop from an empty queue");

endmodule

// ===== rtl/lzsd_back.sv =====
// History engine: writes literal and copied bytes to the history memory, reads copy
// sources with a registered read and a bypass, and holds the result register.
// Depends on lzsd_pkg, lzsd_if.
module lzsd_back #(
   parameter int HISTORY_DEPTH = lzsd_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  lzsd_pkg::head_type  q_head,
   output logic                q_pop,
   lzsd_rsp_if.source          rsp_if
);
   import lzsd_pkg::*;

   localparam int AW = $clog2(HISTORY_DEPTH);

   logic [7:0]  history_mem [HISTORY_DEPTH];

   entry_type   b_ff;
   logic        b_valid_ff;
   logic        fwd_ff;
   logic [7:0]  rd_data_ff;
   logic [7:0]  last_data_ff;
   logic [7:0]  b_data;
   logic        b_adv;
   logic        b_writes;
   logic        fwd_in;

   logic        rsp_valid_ff;
   logic        out_valid_ff;
   logic [7:0]  out_byte_ff;
   logic        copy_pending_ff;
   logic        done_res_ff;
   status_type  status_ff;

   assign b_adv    = b_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign q_pop    = q_head.not_empty && (!b_valid_ff || b_adv);
   assign b_writes = b_adv && (b_ff.op != OP_NONE);

   // the stage ahead writes this cycle; a read of that same slot takes the bypass
   assign fwd_in = b_writes && (b_ff.dst[AW-1:0] == q_head.entry.src[AW-1:0]);

   always_comb begin
      case (b_ff.op)
         OP_LIT:  b_data = b_ff.data;
         OP_COPY: b_data = fwd_ff ? last_data_ff : rd_data_ff;
         default: b_data = 8'h00;
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop && q_head.entry.op == OP_COPY) begin
         rd_data_ff <= history_mem[q_head.entry.src[AW-1:0]];
      end
      if (b_writes) begin
         history_mem[b_ff.dst[AW-1:0]] <= b_data;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         b_ff   <= q_head.entry;
         fwd_ff <= fwd_in;
      end
      if (b_writes) begin
         last_data_ff <= b_data;
      end
      if (b_adv) begin
         out_valid_ff    <= (b_ff.op != OP_NONE);
         out_byte_ff     <= b_data;
         copy_pending_ff <= b_ff.copy_pending;
         done_res_ff     <= b_ff.done_res;
         status_ff       <= b_ff.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            b_valid_ff <= 1'b1;
         end else if (b_adv) begin
            b_valid_ff <= 1'b0;
         end
         if (b_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.out_valid    = out_valid_ff;
   assign rsp_if.out_byte     = out_byte_ff;
   assign rsp_if.copy_pending = copy_pending_ff;
   assign rsp_if.done_res     = done_res_ff;
   assign rsp_if.status       = status_ff;

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !b_adv |=> b_valid_ff)
      else $error("operation lost from the history stage");

   a_idle_no_byte: assert property (@(posedge clock) disable iff (reset)
      b_adv && b_ff.op == OP_NONE |=> rsp_if.out_byte == 8'h00)
      else $error("byte presented for a request without output");

endmodule

// ===== rtl/lz_stream_decompressor.sv =====
// LZ stream decompressor, top level. Parser, queue and history engine.
// Depends on lzsd_pkg, lzsd_if, lzsd_front, lzsd_queue, lzsd_back.
//
// Takes one request per cycle (a compressed byte or a copy tick) and returns exactly one
// result per request, in order, sustaining one item per clock with both sides flowing.
// Each request passes the queue, the engine stage and the result register; the parser
// writes the queue as it takes the request, the history read lands in the engine stage
// at the pop, the result register loads as it advances. The history memory has one write
// port and one registered read port; a copy that reads the byte written just before it
// (overlapping copies such as offset one back) takes it from a bypass register. History
// contents are not cleared at reset; every legal copy reads bytes already written.
// The user writes output_size (csr_wdata) only while the block is idle; the block does
// not enforce this. Decoding stops at a token boundary once output count reaches the size.
module lz_stream_decompressor #(
   parameter int HISTORY_DEPTH = lzsd_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   lzsd_req_if.sink                     req_if,
   lzsd_rsp_if.source                   rsp_if,
   input  logic                         csr_we,
   input  logic [lzsd_pkg::SIZE_W-1:0]  csr_wdata
);
   import lzsd_pkg::*;

   push_type q_push;
   head_type q_head;
   logic     q_full;
   logic     q_pop;

   lzsd_front #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .q_push    (q_push)
   );

   lzsd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_full (q_full),
      .q_pop  (q_pop),
      .q_head (q_head)
   );

   lzsd_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .q_head (q_head),
      .q_pop  (q_pop),
      .rsp_if (rsp_if)
   );

endmodule
